>>> hdl/sde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sde_pkg: shared types and constants of the savgol derivative estimator
// widths, scale constants, weight tables and the divider request/response
// ----------------------------------------------------------------------------
package sde_pkg;

  localparam int WINDOW   = 9;
  localparam int POS_W    = $clog2(WINDOW);
  localparam int SAMPLE_W = 20;
  localparam int TIME_W   = 32;
  localparam int SLOPE_W  = 32;
  localparam int CURV_W   = 40;

  // weight widths, signed
  localparam int W1_W = 4;
  localparam int W2_W = 6;

  // sum of |first weights| is 20, of |second weights| is 140
  localparam int S1_W = SAMPLE_W + 6;
  localparam int S2_W = SAMPLE_W + 9;
  localparam int M1_W = S1_W - 1;
  localparam int M2_W = S2_W - 1;

  // 400000 = 3125 << 7, 32e12 = 5^12 << 17
  localparam int K1    = 3125;
  localparam int K1_W  = 12;
  localparam int K1_SH = 7;
  localparam int K2    = 244140625;
  localparam int K2_W  = 28;
  localparam int K2_SH = 17;
  localparam int SLOPE_DIV = 3;
  localparam int CURV_DIV  = 231;
  localparam int CURV_DIV_W = 8;

  localparam int N1_W   = M1_W + K1_W + K1_SH;
  localparam int N2_W   = M2_W + K2_W + K2_SH;
  localparam int NUM_W  = (N1_W > N2_W) ? N1_W : N2_W;
  localparam int DEN1_W = TIME_W + 2;
  localparam int SQ_W   = 2 * TIME_W;
  localparam int DEN_W  = SQ_W + CURV_DIV_W;
  localparam int CNT_W  = $clog2(NUM_W + 1);

  localparam int SPAN_MIN = 800;
  localparam int SPAN_DEF = 4000;

  localparam logic [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
  localparam logic [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};
  localparam logic [CURV_W-1:0]  CURV_MAX  = {1'b0, {(CURV_W-1){1'b1}}};
  localparam logic [CURV_W-1:0]  CURV_MIN  = {1'b1, {(CURV_W-1){1'b0}}};

  // input queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic                       clr;
    logic signed [SAMPLE_W-1:0] pressure;
    logic [TIME_W-1:0]          time_us;
  } item_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

  // first derivative weights, oldest to newest
  function automatic logic signed [W1_W-1:0] w_first(input logic [POS_W-1:0] k);
    logic signed [W1_W-1:0] w;
    unique case (k)
      4'd0:    w = -4'sd4;
      4'd1:    w = -4'sd3;
      4'd2:    w = -4'sd2;
      4'd3:    w = -4'sd1;
      4'd4:    w = 4'sd0;
      4'd5:    w = 4'sd1;
      4'd6:    w = 4'sd2;
      4'd7:    w = 4'sd3;
      4'd8:    w = 4'sd4;
      default: w = 4'sd0;
    endcase
    return w;
  endfunction

  // second derivative weights, oldest to newest
  function automatic logic signed [W2_W-1:0] w_second(input logic [POS_W-1:0] k);
    logic signed [W2_W-1:0] w;
    unique case (k)
      4'd0:    w = 6'sd28;
      4'd1:    w = 6'sd7;
      4'd2:    w = -6'sd8;
      4'd3:    w = -6'sd17;
      4'd4:    w = -6'sd20;
      4'd5:    w = -6'sd17;
      4'd6:    w = -6'sd8;
      4'd7:    w = 6'sd7;
      4'd8:    w = 6'sd28;
      default: w = 6'sd0;
    endcase
    return w;
  endfunction

endpackage

>>> hdl/savgol_derivative_estimator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// savgol_derivative_estimator_unit: 9-point least-squares slope and curvature
// input queue, window and sum engine, shared serial divider
// ----------------------------------------------------------------------------
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   kind_i, pressure_i, time_us_i
// out      output     out_valid_o / out_stall_i slope_o, curvature_o, ready_res_o
//
// a clear word, or a sample on a filling window, loads the result register at the
// edge that takes it from the 2-deep input queue
// a sample on a full window goes through nine taps, three scaling steps and two
// passes through the bit-serial divider, one shift per quotient bit
// out_stall_i holds the result register; no word leaves the queue until it is taken
// reset is asynchronous, active low, and empties the window; both values read 0
// ----------------------------------------------------------------------------
module savgol_derivative_estimator_unit import sde_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       kind_i,
  input  logic signed [SAMPLE_W-1:0] pressure_i,
  input  logic [TIME_W-1:0]          time_us_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SLOPE_W-1:0]  slope_o,
  output logic signed [CURV_W-1:0]   curvature_o,
  output logic                       ready_res_o
);

  logic               item_valid;
  item_t              item;
  logic               pop;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic [SLOPE_W-1:0] slope;
  logic [CURV_W-1:0]  curv;

  sde_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .pressure_i   (pressure_i),
    .time_us_i    (time_us_i),
    .pop_i        (pop),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  sde_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  sde_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .slope_o      (slope),
    .curv_o       (curv),
    .ready_res_o  (ready_res_o)
  );

  assign slope_o     = slope;
  assign curvature_o = curv;

endmodule

>>> hdl/sde_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sde_queue: input front end
// takes words from the input channel, tags clear words, and holds them in a
// short queue until the back end takes them
// ----------------------------------------------------------------------------
module sde_queue import sde_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       kind_i,
  input  logic signed [SAMPLE_W-1:0] pressure_i,
  input  logic [TIME_W-1:0]          time_us_i,
  input  logic                       pop_i,
  output logic                       item_valid_o,
  output item_t                      item_o
);

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push, pop;
  item_t             in_item;

  assign in_stall_o   = (cnt_q == QCNT_W'(QDEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign push         = in_valid_i && !in_stall_o;
  assign pop          = pop_i && item_valid_o;
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    in_item.clr      = kind_i;
    in_item.pressure = pressure_i;
    in_item.time_us  = time_us_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("queue level above depth");

  a_pop_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> item_valid_o)
    else $error("back end popped an empty queue");

  a_cnt_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue level did not follow a push");

endmodule

>>> hdl/sde_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sde_div: shared restoring divider
// unsigned quotient of a NUM_W-bit numerator by a DEN_W-bit divisor,
// one quotient bit per cycle
// ----------------------------------------------------------------------------
module sde_div import sde_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] acc_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [DEN_W:0]   trial, diff;
  logic             ge;

  // numerator bits shift out of acc_q as quotient bits shift in
  assign trial = {rem_q, acc_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= req_i.num;
      rem_q <= '0;
      den_q <= req_i.den;
    end else if (busy_q) begin
      acc_q <= {acc_q[NUM_W-2:0], ge};
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_busy_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != '0 && cnt_q <= CNT_W'(NUM_W)))
    else $error("divider step count out of range");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

endmodule

>>> hdl/sde_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sde_back: window and derivative engine
// keeps the sample ring, forms both weighted sums over the nine-sample window, scales
// them through the shared divider and holds the result word
// ----------------------------------------------------------------------------
module sde_back import sde_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  item_t               item_i,
  output logic                pop_o,
  output div_req_t            div_req_o,
  input  div_rsp_t            div_rsp_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SLOPE_W-1:0]  slope_o,
  output logic [CURV_W-1:0]   curv_o,
  output logic                ready_res_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_SPAN,
    ST_MUL,
    ST_SCALE,
    ST_DIV1,
    ST_DIV2
  } state_e;

  state_e                     state_q;
  logic [POS_W-1:0]           wr_pos_q, rd_ptr_q, k_q;
  logic                       full_q;
  logic [SLOPE_W-1:0]         held_slope_q, out_slope_q;
  logic [CURV_W-1:0]          held_curv_q, out_curv_q;
  logic                       out_valid_q, out_ready_q;

  logic signed [SAMPLE_W-1:0] ring_p_q [WINDOW];
  logic [TIME_W-1:0]          ring_t_q [WINDOW];
  logic signed [S1_W-1:0]     s1_q;
  logic signed [S2_W-1:0]     s2_q;
  logic [TIME_W-1:0]          t_old_q, t_new_q, span_q;
  logic [M1_W-1:0]            mag1_q;
  logic [M2_W-1:0]            mag2_q;
  logic                       neg1_q, neg2_q;
  logic [N1_W-1:0]            num1_q;
  logic [N2_W-1:0]            num2_q;
  logic [DEN1_W-1:0]          den1_q;
  logic [SQ_W-1:0]            sq_q;
  logic [DEN_W-1:0]           den2_q;

  logic                       pop;
  logic [POS_W-1:0]           pos_next, rd_next;
  logic                       full_next;
  logic signed [SAMPLE_W-1:0] rd_p;
  logic [TIME_W-1:0]          rd_t, span_raw, span_sel;
  logic signed [S1_W-1:0]     w1_x, p1_x, prod1;
  logic signed [S2_W-1:0]     w2_x, p2_x, prod2;
  logic [S1_W-1:0]            abs1;
  logic [S2_W-1:0]            abs2;
  logic [M1_W+K1_W-1:0]       mul1;
  logic [M2_W+K2_W-1:0]       mul2;
  logic [NUM_W-1:0]           quo;
  logic                       slope_big, curv_big;
  logic [SLOPE_W-1:0]         slope_mag, slope_sat;
  logic [CURV_W-1:0]          curv_mag, curv_sat;

  assign pop   = (state_q == ST_IDLE) && item_valid_i && !out_valid_q;
  assign pop_o = pop;

  assign pos_next  = (wr_pos_q == POS_W'(WINDOW - 1)) ? '0 : wr_pos_q + 1'b1;
  assign full_next = full_q || (pos_next == '0);
  assign rd_next   = (rd_ptr_q == POS_W'(WINDOW - 1)) ? '0 : rd_ptr_q + 1'b1;

  assign rd_p = ring_p_q[rd_ptr_q];
  assign rd_t = ring_t_q[rd_ptr_q];

  // one weighted tap per cycle, oldest first
  assign w1_x  = S1_W'(w_first(k_q));
  assign p1_x  = S1_W'(rd_p);
  assign prod1 = w1_x * p1_x;
  assign w2_x  = S2_W'(w_second(k_q));
  assign p2_x  = S2_W'(rd_p);
  assign prod2 = w2_x * p2_x;

  // tight spacing falls back to h = 500 us
  assign span_raw = t_new_q - t_old_q;
  assign span_sel = (span_raw <= TIME_W'(SPAN_MIN)) ? TIME_W'(SPAN_DEF) : span_raw;

  assign abs1 = s1_q[S1_W-1] ? (~s1_q + 1'b1) : s1_q;
  assign abs2 = s2_q[S2_W-1] ? (~s2_q + 1'b1) : s2_q;

  assign mul1 = (M1_W+K1_W)'(mag1_q) * (M1_W+K1_W)'(K1);
  assign mul2 = (M2_W+K2_W)'(mag2_q) * (M2_W+K2_W)'(K2);

  // magnitude quotient, then sign and clamp
  assign quo       = div_rsp_i.quo;
  assign slope_big = (quo >= (NUM_W'(1) << (SLOPE_W - 1)));
  assign slope_mag = quo[SLOPE_W-1:0];
  assign curv_big  = (quo >= (NUM_W'(1) << (CURV_W - 1)));
  assign curv_mag  = quo[CURV_W-1:0];

  always_comb begin
    if (neg1_q) begin
      slope_sat = slope_big ? SLOPE_MIN : (~slope_mag + 1'b1);
    end else begin
      slope_sat = slope_big ? SLOPE_MAX : slope_mag;
    end
    if (neg2_q) begin
      curv_sat = curv_big ? CURV_MIN : (~curv_mag + 1'b1);
    end else begin
      curv_sat = curv_big ? CURV_MAX : curv_mag;
    end
  end

  always_comb begin
    div_req_o.start = 1'b0;
    div_req_o.num   = NUM_W'(num1_q);
    div_req_o.den   = DEN_W'(den1_q);
    if (state_q == ST_SCALE) begin
      div_req_o.start = 1'b1;
    end else if (state_q == ST_DIV1) begin
      div_req_o.start = div_rsp_i.done;
      div_req_o.num   = NUM_W'(num2_q);
      div_req_o.den   = den2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      wr_pos_q     <= '0;
      rd_ptr_q     <= '0;
      k_q          <= '0;
      full_q       <= 1'b0;
      held_slope_q <= '0;
      held_curv_q  <= '0;
      out_valid_q  <= 1'b0;
      out_slope_q  <= '0;
      out_curv_q   <= '0;
      out_ready_q  <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop) begin
            if (item_i.clr) begin
              wr_pos_q     <= '0;
              full_q       <= 1'b0;
              held_slope_q <= '0;
              held_curv_q  <= '0;
              out_valid_q  <= 1'b1;
              out_slope_q  <= '0;
              out_curv_q   <= '0;
              out_ready_q  <= 1'b0;
            end else begin
              wr_pos_q <= pos_next;
              full_q   <= full_next;
              if (full_next) begin
                rd_ptr_q <= pos_next;
                k_q      <= '0;
                state_q  <= ST_MAC;
              end else begin
                out_valid_q <= 1'b1;
                out_slope_q <= held_slope_q;
                out_curv_q  <= held_curv_q;
                out_ready_q <= 1'b0;
              end
            end
          end
        end
        ST_MAC: begin
          rd_ptr_q <= rd_next;
          k_q      <= k_q + 1'b1;
          if (k_q == POS_W'(WINDOW - 1)) begin
            state_q <= ST_SPAN;
          end
        end
        ST_SPAN:  state_q <= ST_MUL;
        ST_MUL:   state_q <= ST_SCALE;
        ST_SCALE: state_q <= ST_DIV1;
        ST_DIV1: begin
          if (div_rsp_i.done) begin
            held_slope_q <= slope_sat;
            state_q      <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (div_rsp_i.done) begin
            held_curv_q <= curv_sat;
            out_valid_q <= 1'b1;
            out_slope_q <= held_slope_q;
            out_curv_q  <= curv_sat;
            out_ready_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && !item_i.clr) begin
      ring_p_q[wr_pos_q] <= item_i.pressure;
      ring_t_q[wr_pos_q] <= item_i.time_us;
      s1_q <= '0;
      s2_q <= '0;
    end
    if (state_q == ST_MAC) begin
      s1_q <= s1_q + prod1;
      s2_q <= s2_q + prod2;
      if (k_q == '0) begin
        t_old_q <= rd_t;
      end
      if (k_q == POS_W'(WINDOW - 1)) begin
        t_new_q <= rd_t;
      end
    end
    if (state_q == ST_SPAN) begin
      span_q <= span_sel;
      mag1_q <= abs1[M1_W-1:0];
      neg1_q <= s1_q[S1_W-1];
      mag2_q <= abs2[M2_W-1:0];
      neg2_q <= s2_q[S2_W-1];
    end
    if (state_q == ST_MUL) begin
      num1_q <= {mul1, {K1_SH{1'b0}}};
      num2_q <= {mul2, {K2_SH{1'b0}}};
      den1_q <= DEN1_W'(span_q) * DEN1_W'(SLOPE_DIV);
      sq_q   <= SQ_W'(span_q) * SQ_W'(span_q);
    end
    if (state_q == ST_SCALE) begin
      den2_q <= DEN_W'(sq_q) * DEN_W'(CURV_DIV);
    end
  end

  assign out_valid_o = out_valid_q;
  assign slope_o     = out_slope_q;
  assign curv_o      = out_curv_q;
  assign ready_res_o = out_ready_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pos_q < POS_W'(WINDOW))
    else $error("write position outside window");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ready_q) |-> full_q)
    else $error("live result without a full window");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && item_i.clr) |=> (!full_q && held_slope_q == '0 && held_curv_q == '0))
    else $error("clear word did not empty the window");

  a_busy_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !out_valid_q)
    else $error("computing while a result word is pending");

endmodule
